// ----- src/ipv4rx_pkg.sv -----
// IPv4 receive header check: shared types, codes and constants.
// No dependencies; imported by every module of the block.
package ipv4rx_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned HbW    = 6;
  localparam int unsigned OutDataW = 56;

  localparam logic [AddrW-1:0] LocalAddrReset = 32'hC0A8_0164;
  localparam logic [AddrW-1:0] BroadcastAddr  = 32'hFFFF_FFFF;
  localparam logic [3:0]       IpVersion4     = 4'd4;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  // header word positions
  localparam logic [PosW-1:0] PosVerLen = 4'd0;
  localparam logic [PosW-1:0] PosTotLen = 4'd1;
  localparam logic [PosW-1:0] PosProto  = 4'd4;
  localparam logic [PosW-1:0] PosCsum   = 4'd5;
  localparam logic [PosW-1:0] PosSrcHi  = 4'd6;
  localparam logic [PosW-1:0] PosSrcLo  = 4'd7;
  localparam logic [PosW-1:0] PosDstHi  = 4'd8;
  localparam logic [PosW-1:0] PosLast   = 4'd9;

  typedef enum logic [2:0] {
    VERDICT_SHORT   = 3'd0,
    VERDICT_BAD_VER = 3'd1,
    VERDICT_NOT_US  = 3'd2,
    VERDICT_BAD_SUM = 3'd3,
    VERDICT_UNK_PRO = 3'd4,
    VERDICT_DELIVER = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    UPPER_ICMP = 2'd0,
    UPPER_TCP  = 2'd1,
    UPPER_UDP  = 2'd2
  } upper_t;

  // header view handed from the accumulator to the verdict stage
  typedef struct packed {
    logic             emit;
    logic             short_frame;
    logic [7:0]       ver_len;
    logic [WordW-1:0] tot_len;
    logic [7:0]       proto;
    logic [WordW-1:0] csum;
    logic [WordW-1:0] sum;
    logic [AddrW-1:0] src;
    logic [AddrW-1:0] dst;
  } hdr_t;

endpackage

// ----- src/ipv4_receive_header_check.sv -----
// IPv4 receive header check, top level: input register, flow control, address register.
// Depends on ipv4rx_pkg, ipv4rx_accum, ipv4rx_verdict.
//
//  port group  dir  payload                                   handshake
//  in_         in   tdata[15:0] header_word, tlast frame_end  tvalid/tready
//  out_        out  tuser verdict; tdata upper/src/hb/plen    tvalid/tready
//  cfg_        in   wr_data[31:0] local_address               wr_en
//
// One word per cycle sustained unless a full, unread result register stalls it;
// a verdict passes the input register, then the result register.
// Synchronous active-low reset; local address resets to 192.168.1.100.
// A full, unread result register stalls only words that would produce a result.
module ipv4_receive_header_check (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ipv4rx_pkg::WordW-1:0]     in_tdata,   // [15:0] header_word
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [2:0]                       out_tuser,  // [2:0] verdict
  // [1:0] upper_protocol, [33:2] source_address, [39:34] header_bytes,
  // [55:40] data_len
  output logic [ipv4rx_pkg::OutDataW-1:0]  out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [ipv4rx_pkg::AddrW-1:0]     cfg_wr_data
);
  import ipv4rx_pkg::*;

  logic             s1_valid_r, s1_valid_nxt;
  logic [WordW-1:0] s1_word_r;
  logic             s1_end_r;
  logic [AddrW-1:0] local_addr_r;
  logic             out_free;
  logic             s1_go;
  logic             in_take;
  hdr_t             hdr;

  assign out_free     = !out_tvalid || out_tready;
  assign s1_go        = s1_valid_r && (!hdr.emit || out_free);
  assign in_tready    = !s1_valid_r || s1_go;
  assign in_take      = in_tvalid && in_tready;
  assign s1_valid_nxt = in_take || (s1_valid_r && !s1_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      local_addr_r <= LocalAddrReset;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_wr_en) begin
        local_addr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_tdata;
      s1_end_r  <= in_tlast;
    end
  end

  ipv4rx_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (s1_valid_r),
    .word       (s1_word_r),
    .word_end   (s1_end_r),
    .step       (s1_go),
    .hdr        (hdr)
  );

  ipv4rx_verdict u_verdict (
    .clk        (clk),
    .rst_n      (rst_n),
    .hdr        (hdr),
    .local_addr (local_addr_r),
    .load       (s1_go && hdr.emit),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_go && hdr.emit && out_tvalid && !out_tready))
    else $error("verdict loaded over an unread result");

  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_word_r) && $stable(s1_end_r)))
    else $error("stalled input word lost");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input not ready with empty input register");

endmodule

// ----- src/ipv4rx_accum.sv -----
// IPv4 receive header check: word position, ones-complement sum, field capture.
// Depends on ipv4rx_pkg.
module ipv4rx_accum (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            word_valid,
  input  logic [ipv4rx_pkg::WordW-1:0]    word,
  input  logic                            word_end,
  input  logic                            step,
  output ipv4rx_pkg::hdr_t                hdr
);
  import ipv4rx_pkg::*;

  logic [PosW-1:0]  pos_r, pos_nxt;
  logic [WordW-1:0] sum_r, sum_nxt;
  logic             skip_r, skip_nxt;
  logic [7:0]       ver_len_r, ver_len_nxt;
  logic [WordW-1:0] tot_len_r, tot_len_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [WordW-1:0] csum_r, csum_nxt;
  logic [AddrW-1:0] src_r, src_nxt;
  logic [WordW-1:0] dst_hi_r, dst_hi_nxt;

  logic [WordW:0]   sum_wide;
  logic [WordW-1:0] sum_fold;
  logic [WordW-1:0] sum_upd;
  logic             at_last;
  logic             emit;

  assign sum_wide = {1'b0, sum_r} + {1'b0, word};
  assign sum_fold = sum_wide[WordW-1:0] + {{(WordW-1){1'b0}}, sum_wide[WordW]};
  assign sum_upd  = (pos_r == PosCsum) ? sum_r : sum_fold;
  assign at_last  = (pos_r == PosLast);
  assign emit     = word_valid && !skip_r && (at_last || word_end);

  always_comb begin
    hdr             = '0;
    hdr.emit        = emit;
    hdr.short_frame = !at_last;
    hdr.ver_len     = ver_len_r;
    hdr.tot_len     = tot_len_r;
    hdr.proto       = proto_r;
    hdr.csum        = csum_r;
    hdr.sum         = sum_upd;
    hdr.src         = src_r;
    hdr.dst         = {dst_hi_r, word};
  end

  always_comb begin
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    skip_nxt    = skip_r;
    ver_len_nxt = ver_len_r;
    tot_len_nxt = tot_len_r;
    proto_nxt   = proto_r;
    csum_nxt    = csum_r;
    src_nxt     = src_r;
    dst_hi_nxt  = dst_hi_r;
    if (step) begin
      if (skip_r) begin
        if (word_end) begin
          skip_nxt = 1'b0;
        end
      end else begin
        sum_nxt = sum_upd;
        unique case (pos_r)
          PosVerLen: ver_len_nxt = word[WordW-1:8];
          PosTotLen: tot_len_nxt = word;
          PosProto:  proto_nxt   = word[7:0];
          PosCsum:   csum_nxt    = word;
          PosSrcHi:  src_nxt     = {word, src_r[WordW-1:0]};
          PosSrcLo:  src_nxt     = {src_r[AddrW-1:WordW], word};
          PosDstHi:  dst_hi_nxt  = word;
          default:   ;
        endcase
        if (emit) begin
          pos_nxt  = '0;
          sum_nxt  = '0;
          skip_nxt = at_last && !word_end;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      skip_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      skip_r <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ver_len_r <= ver_len_nxt;
    tot_len_r <= tot_len_nxt;
    proto_r   <= proto_nxt;
    csum_r    <= csum_nxt;
    src_r     <= src_nxt;
    dst_hi_r  <= dst_hi_nxt;
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PosLast)
    else $error("word position past last header word");

  a_skip_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> (pos_r == '0 && sum_r == '0))
    else $error("skipping with a partial header pending");

  a_emit_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (step && emit) |=> (pos_r == '0))
    else $error("position not cleared after verdict");

endmodule

// ----- src/ipv4rx_verdict.sv -----
// IPv4 receive header check: verdict decision and result register.
// Depends on ipv4rx_pkg.
module ipv4rx_verdict (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ipv4rx_pkg::hdr_t                 hdr,
  input  logic [ipv4rx_pkg::AddrW-1:0]     local_addr,
  input  logic                             load,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [2:0]                       out_tuser,
  output logic [ipv4rx_pkg::OutDataW-1:0]  out_tdata
);
  import ipv4rx_pkg::*;

  logic             valid_r, valid_nxt;
  verdict_t         verdict_r, verdict_nxt;
  upper_t           upper_r, upper_nxt;
  logic [AddrW-1:0] src_r, src_nxt;
  logic [HbW-1:0]   hb_r, hb_nxt;
  logic [WordW-1:0] plen_r, plen_nxt;

  logic [HbW-1:0]   hb;
  logic [WordW-1:0] hb_ext;
  logic [WordW-1:0] plen;
  logic [WordW-1:0] csum_calc;
  verdict_t         verdict;
  upper_t           upper;

  assign hb        = {hdr.ver_len[3:0], 2'b00};
  assign hb_ext    = {{(WordW-HbW){1'b0}}, hb};
  assign plen      = (hdr.tot_len > hb_ext) ? (hdr.tot_len - hb_ext) : '0;
  assign csum_calc = ~hdr.sum;

  always_comb begin
    upper = UPPER_ICMP;
    priority if (hdr.ver_len[7:4] != IpVersion4) begin
      verdict = VERDICT_BAD_VER;
    end else if (hdr.dst != local_addr && hdr.dst != BroadcastAddr) begin
      verdict = VERDICT_NOT_US;
    end else if (csum_calc != hdr.csum) begin
      verdict = VERDICT_BAD_SUM;
    end else if (hdr.proto == ProtoIcmp) begin
      verdict = VERDICT_DELIVER;
    end else if (hdr.proto == ProtoTcp) begin
      verdict = VERDICT_DELIVER;
      upper   = UPPER_TCP;
    end else if (hdr.proto == ProtoUdp) begin
      verdict = VERDICT_DELIVER;
      upper   = UPPER_UDP;
    end else begin
      verdict = VERDICT_UNK_PRO;
    end
  end

  always_comb begin
    valid_nxt   = valid_r && !out_tready;
    verdict_nxt = verdict_r;
    upper_nxt   = upper_r;
    src_nxt     = src_r;
    hb_nxt      = hb_r;
    plen_nxt    = plen_r;
    if (load) begin
      valid_nxt = 1'b1;
      if (hdr.short_frame) begin
        verdict_nxt = VERDICT_SHORT;
        upper_nxt   = UPPER_ICMP;
        src_nxt     = '0;
        hb_nxt      = '0;
        plen_nxt    = '0;
      end else begin
        verdict_nxt = verdict;
        upper_nxt   = upper;
        src_nxt     = hdr.src;
        hb_nxt      = hb;
        plen_nxt    = plen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
    upper_r   <= upper_nxt;
    src_r     <= src_nxt;
    hb_r      <= hb_nxt;
    plen_r    <= plen_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = verdict_r;
  assign out_tdata  = {plen_r, hb_r, src_r, upper_r};

endmodule
